// ===== rtl/core/rvs_pkg.sv =====
// Package: shared types, codes and constants of the receiver voter selector.
package rvs_pkg;

  localparam int NUM_RX        = 8;
  localparam int RX_W          = $clog2(NUM_RX);
  localparam int MIN_REVOTE_MS = 100;
  localparam int MS_W          = 14;
  localparam int HYS_W         = 10;
  localparam int LVL_W         = 8;
  localparam int TMR_W         = 15;
  localparam int PROD_W        = LVL_W + HYS_W;
  localparam logic [PROD_W-1:0] STRONG_LIMIT = PROD_W'(100 * 256);
  localparam logic [HYS_W-1:0]  HYS_RESET    = HYS_W'(307);

  typedef enum logic [2:0] {
    OP_SQUELCH = 3'd0,
    OP_LEVEL   = 3'd1,
    OP_TICK    = 3'd2,
    OP_MUTE    = 3'd3,
    OP_RESET   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    V_MUTED     = 3'd0,
    V_IDLE      = 3'd1,
    V_VOTING    = 3'd2,
    V_RECV      = 3'd3,
    V_CLOSEWAIT = 3'd4,
    V_SWITCH    = 3'd5
  } vmode_t;

  localparam logic [1:0] MT_NONE    = 2'd0;
  localparam logic [1:0] MT_CONTENT = 2'd1;
  localparam logic [1:0] MT_FULL    = 2'd2;

  localparam logic [2:0] REG_VOTING    = 3'd0;
  localparam logic [2:0] REG_CLOSE     = 3'd1;
  localparam logic [2:0] REG_REVOTE    = 3'd2;
  localparam logic [2:0] REG_SWITCH    = 3'd3;
  localparam logic [2:0] REG_HYST      = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the input item and apply level/squelch writes
    logic scan_clr;    // start a best-receiver scan
    logic scan_step;   // examine one receiver
    logic exec;        // run the voter decision for the captured item
  } rvs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_scan;   // captured item needs a full best search
    logic scan_last;   // scan pointer at the last receiver
  } rvs_sts_t;

endpackage

// ===== rtl/core/rvs_ctrl.sv =====
// Controller: sequences capture, optional best-receiver scan, decision and result.
module rvs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rvs_pkg::rvs_cmd_t cmd,
  input  rvs_pkg::rvs_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_EXEC, S_OUT} state_t;
  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_LOAD: begin
        cmd.scan_clr = 1'b1;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_IDLE: cmd.load = in_valid;
      default: ;
    endcase
  end

  // Advance through the phases of one transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_LOAD;
        S_LOAD: state <= sts.need_scan ? S_SCAN : S_EXEC;
        S_SCAN: if (sts.scan_last) state <= S_EXEC;
        S_EXEC: state <= S_OUT;
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rvs_dp.sv =====
// Datapath: receiver tables, best tracking, voter state, timer and mute masks.
module rvs_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  rvs_pkg::rvs_cmd_t         cmd,
  output rvs_pkg::rvs_sts_t         sts,
  input  logic [2:0]                opcode,
  input  logic [2:0]                rx_index,
  input  logic                      squelch_open,
  input  logic [7:0]                signal_level,
  input  logic [1:0]                mute_request,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_idx,
  input  logic [31:0]               cfg_data,
  output logic [31:0]               cfg_rdata_of_idx,
  input  logic [2:0]                cfg_ridx,
  output logic [2:0]                voter_state,
  output logic                      squelch_out,
  output logic [2:0]                active_rx,
  output logic                      active_valid,
  output logic [7:0]                unmuted_mask,
  output logic [7:0]                fully_muted_mask,
  output logic [7:0]                level_out,
  output logic                      level_valid
);

  localparam int N  = rvs_pkg::NUM_RX;
  localparam int RW = rvs_pkg::RX_W;
  localparam int MASK_N = (N < 8) ? N : 8;

  // Configuration
  logic [rvs_pkg::MS_W-1:0]  voting_delay_ms, close_revote_delay_ms;
  logic [rvs_pkg::MS_W-1:0]  revote_interval_ms, switch_delay_ms;
  logic [rvs_pkg::HYS_W-1:0] hysteresis_q8;

  // State
  rvs_pkg::vmode_t mode, mode_next;
  logic [1:0]      mute_mode, mute_mode_next;
  logic [N-1:0]    rx_squelch;
  logic [7:0]      rx_level [N];
  logic [1:0]      rx_mute [N];
  logic [1:0]      rx_mute_next [N];
  logic [RW-1:0]   best_rx, current_rx, switch_target;
  logic [RW-1:0]   best_rx_next, current_rx_next, switch_target_next;
  logic            best_ok, current_ok, target_ok;
  logic            best_ok_next, current_ok_next, target_ok_next;
  logic [rvs_pkg::TMR_W-1:0] ms_timer, ms_timer_next;
  logic            timer_on, timer_on_next;

  // Captured item
  logic [2:0]    op;
  logic [RW-1:0] r;
  logic          r_ok, open, sq_changed;
  logic [7:0]    lvl;
  logic [1:0]    m;
  logic [RW-1:0] scan_ptr;
  logic [7:0]    lvl_out_next;
  logic          lvl_ok_next;

  logic          r_in_ok;
  assign r_in_ok = (32'(rx_index) < N);

  assign sts.need_scan = (op == rvs_pkg::OP_SQUELCH) && r_ok && sq_changed &&
                         (!best_ok || (r == best_rx && !open));
  assign sts.scan_last = (32'(scan_ptr) == N - 1);

  // Configuration write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      voting_delay_ms       <= '0;
      close_revote_delay_ms <= '0;
      revote_interval_ms    <= '0;
      switch_delay_ms       <= '0;
      hysteresis_q8         <= rvs_pkg::HYS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rvs_pkg::REG_VOTING: voting_delay_ms       <= cfg_data[rvs_pkg::MS_W-1:0];
        rvs_pkg::REG_CLOSE:  close_revote_delay_ms <= cfg_data[rvs_pkg::MS_W-1:0];
        rvs_pkg::REG_REVOTE: revote_interval_ms    <= cfg_data[rvs_pkg::MS_W-1:0];
        rvs_pkg::REG_SWITCH: switch_delay_ms       <= cfg_data[rvs_pkg::MS_W-1:0];
        rvs_pkg::REG_HYST:   hysteresis_q8         <= cfg_data[rvs_pkg::HYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_ridx)
      rvs_pkg::REG_VOTING: cfg_rdata_of_idx = 32'(voting_delay_ms);
      rvs_pkg::REG_CLOSE:  cfg_rdata_of_idx = 32'(close_revote_delay_ms);
      rvs_pkg::REG_REVOTE: cfg_rdata_of_idx = 32'(revote_interval_ms);
      rvs_pkg::REG_SWITCH: cfg_rdata_of_idx = 32'(switch_delay_ms);
      rvs_pkg::REG_HYST:   cfg_rdata_of_idx = 32'(hysteresis_q8);
      default:             cfg_rdata_of_idx = '0;
    endcase
  end

  // Capture the item; store level and squelch
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_squelch <= '0;
      for (int i = 0; i < N; i++) rx_level[i] <= '0;
    end else if (cmd.load) begin
      op   <= opcode;
      r    <= rx_index[RW-1:0];
      r_ok <= r_in_ok;
      open <= squelch_open;
      lvl  <= signal_level;
      m    <= mute_request;
      sq_changed <= (rx_squelch[rx_index[RW-1:0]] != squelch_open);
      if ((opcode == rvs_pkg::OP_SQUELCH || opcode == rvs_pkg::OP_LEVEL) && r_in_ok)
        rx_level[rx_index[RW-1:0]] <= signal_level;
      if (opcode == rvs_pkg::OP_SQUELCH && r_in_ok)
        rx_squelch[rx_index[RW-1:0]] <= squelch_open;
    end
  end

  // Comparisons against the hysteresis factor
  function automatic logic strong_f(input logic [7:0] l, input logic [9:0] h);
    strong_f = (rvs_pkg::PROD_W'(l) * rvs_pkg::PROD_W'(h)) > rvs_pkg::STRONG_LIMIT;
  endfunction
  function automatic logic better_f(input logic [7:0] a, input logic [7:0] b,
                                    input logic [9:0] h);
    better_f = rvs_pkg::PROD_W'({a, 8'd0}) > (rvs_pkg::PROD_W'(b) * rvs_pkg::PROD_W'(h));
  endfunction

  // Voter decision for the captured item
  always_comb begin
    logic revote_on, is_cur, exp, do_exit_leaf, do_exit_all;
    logic [1:0] setall;
    logic setall_en;
    mode_next          = mode;
    mute_mode_next     = mute_mode;
    rx_mute_next       = rx_mute;
    best_rx_next       = best_rx;
    best_ok_next       = best_ok;
    current_rx_next    = current_rx;
    current_ok_next    = current_ok;
    switch_target_next = switch_target;
    target_ok_next     = target_ok;
    ms_timer_next      = ms_timer;
    timer_on_next      = timer_on;
    lvl_out_next       = '0;
    lvl_ok_next        = 1'b0;
    revote_on = (32'(revote_interval_ms) >= rvs_pkg::MIN_REVOTE_MS);
    is_cur    = current_ok && r == current_rx;
    exp       = 1'b0;
    setall    = rvs_pkg::MT_NONE;
    setall_en = 1'b0;

    // Best-receiver maintenance (the full search ran in the scan phase)
    if (op == rvs_pkg::OP_SQUELCH && r_ok && sq_changed) begin
      if (!best_ok) begin
        if (open) begin
          best_rx_next = r;
          best_ok_next = 1'b1;
        end
      end else if (r != best_rx && open && rx_level[r] > rx_level[best_rx]) begin
        best_rx_next = r;
      end
    end else if (op == rvs_pkg::OP_LEVEL && r_ok && rx_squelch[r]) begin
      if (!best_ok || !rx_squelch[best_rx] || lvl > rx_level[best_rx]) begin
        best_rx_next = r;
        best_ok_next = 1'b1;
      end
      if (mode >= rvs_pkg::V_RECV && is_cur) begin
        lvl_out_next = lvl;
        lvl_ok_next  = 1'b1;
      end
    end else if (op == rvs_pkg::OP_TICK && timer_on) begin
      if (ms_timer <= rvs_pkg::TMR_W'(1)) begin
        timer_on_next = 1'b0;
        ms_timer_next = '0;
        exp = 1'b1;
      end else begin
        ms_timer_next = ms_timer - rvs_pkg::TMR_W'(1);
      end
    end

    // Transitions, each as a sequence of small actions
    do_exit_leaf = 1'b0;
    do_exit_all  = 1'b0;
    begin : transitions
      logic go_sel, go_idle, go_vote, go_cw, go_recv, go_sw, go_mut, chg;
      logic [RW-1:0] sel_r, chg_r;
      go_sel = 0; go_idle = 0; go_vote = 0; go_cw = 0; go_recv = 0; go_sw = 0;
      go_mut = 0; chg = 0; sel_r = best_rx_next; chg_r = best_rx_next;

      if (op == rvs_pkg::OP_SQUELCH && r_ok && sq_changed) begin
        unique case (mode)
          rvs_pkg::V_IDLE:
            if (open) begin
              if (strong_f(lvl, hysteresis_q8)) go_sel = 1; else go_vote = 1;
            end
          rvs_pkg::V_VOTING:
            if (open) begin
              if (strong_f(lvl, hysteresis_q8)) go_sel = 1;
            end else if (!best_ok_next) go_idle = 1;
          rvs_pkg::V_RECV, rvs_pkg::V_SWITCH:
            if (!open && is_cur) go_cw = 1;
          rvs_pkg::V_CLOSEWAIT:
            if (open && is_cur) go_recv = 1;
          default: ;
        endcase
      end else if (exp) begin
        unique case (mode)
          rvs_pkg::V_VOTING:
            if (best_ok) go_sel = 1; else go_idle = 1;
          rvs_pkg::V_CLOSEWAIT:
            if (best_ok) begin chg = 1; go_recv = 1; end else go_idle = 1;
          rvs_pkg::V_RECV:
            if (best_ok && best_rx != current_rx &&
                better_f(rx_level[best_rx], rx_level[current_rx], hysteresis_q8))
              go_sw = 1;
            else if (revote_on) begin
              timer_on_next = 1'b1;
              ms_timer_next = rvs_pkg::TMR_W'(revote_interval_ms);
            end
          rvs_pkg::V_SWITCH: begin
            if (target_ok && switch_target != current_rx && rx_squelch[switch_target] &&
                better_f(rx_level[switch_target], rx_level[current_rx], hysteresis_q8))
            begin
              chg = 1; chg_r = switch_target;
            end
            go_recv = 1;
          end
          default: ;
        endcase
      end else if (op == rvs_pkg::OP_MUTE && m <= rvs_pkg::MT_FULL) begin
        if (mode == rvs_pkg::V_MUTED) begin
          mute_mode_next = m;
          if (m != rvs_pkg::MT_FULL) begin
            if (best_ok) go_sel = 1; else go_idle = 1;
          end
        end else if (mode >= rvs_pkg::V_RECV && m == rvs_pkg::MT_NONE) begin
          rx_mute_next[current_rx] = rvs_pkg::MT_NONE;
          if (mode == rvs_pkg::V_SWITCH && target_ok)
            rx_mute_next[switch_target] = rvs_pkg::MT_NONE;
          mute_mode_next = rvs_pkg::MT_NONE;
        end else if (m != mute_mode) begin
          mute_mode_next = m;
          if (m == rvs_pkg::MT_NONE) begin
            setall_en = 1; setall = rvs_pkg::MT_NONE;
          end else if (m == rvs_pkg::MT_CONTENT) begin
            setall_en = 1; setall = rvs_pkg::MT_CONTENT;
          end else go_mut = 1;
        end
      end else if (op == rvs_pkg::OP_RESET) begin
        go_mut = 1;
      end

      // change_active runs before the leaf exit of go_receiving
      if (chg) begin
        rx_mute_next[current_rx] = rvs_pkg::MT_CONTENT;
        current_rx_next = chg_r;
        current_ok_next = 1'b1;
        if (mute_mode == rvs_pkg::MT_NONE) rx_mute_next[chg_r] = rvs_pkg::MT_NONE;
        if (mode == rvs_pkg::V_SWITCH) target_ok_next = 1'b0;
      end

      do_exit_all  = go_sel | go_idle | go_vote | go_mut;
      do_exit_leaf = do_exit_all | go_cw | go_recv | go_sw;
      if (do_exit_leaf) begin
        if (mode == rvs_pkg::V_SWITCH && target_ok_next)
          rx_mute_next[switch_target] = rvs_pkg::MT_CONTENT;
        target_ok_next = 1'b0;
        timer_on_next  = 1'b0;
      end
      if (do_exit_all && mode >= rvs_pkg::V_RECV) current_ok_next = 1'b0;

      if (go_mut) begin
        mode_next = rvs_pkg::V_MUTED;
        setall_en = 1; setall = rvs_pkg::MT_FULL;
      end
      if (go_idle) begin
        mode_next = rvs_pkg::V_IDLE;
        if (mute_mode_next == rvs_pkg::MT_NONE) begin
          setall_en = 1; setall = rvs_pkg::MT_NONE;
        end
      end
      if (go_vote) begin
        mode_next     = rvs_pkg::V_VOTING;
        timer_on_next = 1'b1;
        ms_timer_next = rvs_pkg::TMR_W'(voting_delay_ms);
      end
      if (go_cw) begin
        mode_next     = rvs_pkg::V_CLOSEWAIT;
        timer_on_next = 1'b1;
        ms_timer_next = rvs_pkg::TMR_W'(close_revote_delay_ms);
      end
      if (go_sw) begin
        mode_next          = rvs_pkg::V_SWITCH;
        timer_on_next      = 1'b1;
        ms_timer_next      = rvs_pkg::TMR_W'(switch_delay_ms);
        switch_target_next = best_rx;
        target_ok_next     = 1'b1;
        if (mute_mode == rvs_pkg::MT_NONE) rx_mute_next[best_rx] = rvs_pkg::MT_NONE;
      end
      if (setall_en) begin
        for (int i = 0; i < N; i++) rx_mute_next[i] = setall;
      end
      if (go_sel) begin
        current_rx_next = sel_r;
        current_ok_next = 1'b1;
        for (int i = 0; i < N; i++) rx_mute_next[i] = rvs_pkg::MT_CONTENT;
        if (mute_mode_next != rvs_pkg::MT_CONTENT) rx_mute_next[sel_r] = rvs_pkg::MT_NONE;
      end
      if (go_sel || go_recv) begin
        mode_next = rvs_pkg::V_RECV;
        if (revote_on) begin
          timer_on_next = 1'b1;
          ms_timer_next = rvs_pkg::TMR_W'(revote_interval_ms);
        end
      end
    end
  end

  // Hold voter state; walk receivers during a scan; commit on decision
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= rvs_pkg::V_MUTED;
      mute_mode   <= rvs_pkg::MT_FULL;
      for (int i = 0; i < N; i++) rx_mute[i] <= rvs_pkg::MT_FULL;
      best_rx     <= '0;
      best_ok     <= 1'b0;
      current_rx  <= '0;
      current_ok  <= 1'b0;
      switch_target <= '0;
      target_ok   <= 1'b0;
      ms_timer    <= '0;
      timer_on    <= 1'b0;
      scan_ptr    <= '0;
      level_out   <= '0;
      level_valid <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_ptr <= '0;
      if (sts.need_scan) best_ok <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rx_squelch[scan_ptr] && (!best_ok || rx_level[scan_ptr] > rx_level[best_rx])) begin
        best_rx <= scan_ptr;
        best_ok <= 1'b1;
      end
      scan_ptr <= scan_ptr + RW'(1);
    end else if (cmd.exec) begin
      mode          <= mode_next;
      mute_mode     <= mute_mode_next;
      rx_mute       <= rx_mute_next;
      best_rx       <= best_rx_next;
      best_ok       <= best_ok_next;
      current_rx    <= current_rx_next;
      current_ok    <= current_ok_next;
      switch_target <= switch_target_next;
      target_ok     <= target_ok_next;
      ms_timer      <= ms_timer_next;
      timer_on      <= timer_on_next;
      level_out     <= lvl_out_next;
      level_valid   <= lvl_ok_next;
    end
  end

  // Present result fields
  always_comb begin
    voter_state  = mode;
    squelch_out  = (mode >= rvs_pkg::V_RECV);
    active_valid = current_ok && squelch_out;
    active_rx    = active_valid ? 3'(current_rx) : 3'd0;
    unmuted_mask     = '0;
    fully_muted_mask = '0;
    for (int i = 0; i < MASK_N; i++) begin
      unmuted_mask[i]     = (rx_mute[i] == rvs_pkg::MT_NONE);
      fully_muted_mask[i] = (rx_mute[i] == rvs_pkg::MT_FULL);
    end
  end

endmodule

// ===== rtl/core/receiver_voter_selector.sv =====
// Top level of the receiver voter selector: controller, datapath and APB port.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    opcode rx_index squelch_open signal_level
//                                               mute_request
//   out       source     out_valid / out_ready  voter_state .. level_valid
//   apb       slave      psel penable pwrite    paddr pwdata prdata (pready high)
//
// A result is valid once the input transfer has passed the load and exec states
// (and the scan state where needed); the next input transfer is accepted only
// after the result is taken in the out state. The scan state comes in when the
// best-receiver search walks every receiver (squelch open on an empty set or
// close of the best receiver); the search examines one receiver a cycle.
// A result holds until out_ready; no new item enters until it is taken.
// Reset (rst, synchronous) gives voter muted, all receivers fully muted.
module receiver_voter_selector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [2:0]  rx_index,
  input  logic        squelch_open,
  input  logic [7:0]  signal_level,
  input  logic [1:0]  mute_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  voter_state,
  output logic        squelch_out,
  output logic [2:0]  active_rx,
  output logic        active_valid,
  output logic [7:0]  unmuted_mask,
  output logic [7:0]  fully_muted_mask,
  output logic [7:0]  level_out,
  output logic        level_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rvs_pkg::rvs_cmd_t cmd;
  rvs_pkg::rvs_sts_t sts;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  rvs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  rvs_dp u_dp (
    .clk, .rst, .cmd, .sts,
    .opcode, .rx_index, .squelch_open, .signal_level, .mute_request,
    .cfg_we, .cfg_idx(paddr[4:2]), .cfg_data(pwdata),
    .cfg_rdata_of_idx(prdata), .cfg_ridx(paddr[4:2]),
    .voter_state, .squelch_out, .active_rx, .active_valid,
    .unmuted_mask, .fully_muted_mask, .level_out, .level_valid
  );

endmodule

// ===== rtl/core/rvs_checker.sv =====
// Port-level checker for the receiver voter selector, bound to the top level.
module rvs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] voter_state,
  input logic       squelch_out,
  input logic       active_valid,
  input logic [2:0] active_rx,
  input logic       level_valid
);

  // One item in flight: no intake while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("intake while result pending");

  // Squelch follows the voter state
  a_squelch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (squelch_out == (voter_state >= rvs_pkg::V_RECV)))
    else $error("squelch_out mismatch");

  // Active receiver only while the voter squelch is open
  a_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && !squelch_out |-> !active_valid && active_rx == 3'd0)
    else $error("active without open squelch");

  // Forwarded level only from an active receiver
  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && level_valid |-> active_valid) else $error("level without active");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(voter_state))
    else $error("result dropped");

endmodule

bind receiver_voter_selector rvs_checker u_rvs_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready,
  .voter_state, .squelch_out, .active_valid, .active_rx, .level_valid
);
